// ===== rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 7;
  localparam int BYTES_W    = 17;
  localparam int STRIDE_W   = BYTES_W + 1;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int LINE_BYTES = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_PUT = 2'd2;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [CNT_W-1:0]   COUNT_RST = 7'd64;
  localparam int                 BYTES_RST = 64;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } fbpa_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_slots;
  } fbpa_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET_MUL,
    S_GET_SUM,
    S_PUT_DIV
  } fbpa_state_t;

endpackage

// ===== rtl/fbpa_queue.sv =====
`timescale 1ns / 1ps

module fbpa_queue #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [IW-1:0] rd_slot,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data
);

  logic [IW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [IW-1:0]    rd_data_r;
  logic [IW-1:0]    rd_addr_r;
  logic             rd_valid_r;

  // An entry never written since the last clear reads back as its own index.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_addr_r  <= rd_addr;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_slot = rd_valid_r ? rd_data_r : rd_addr_r;

endmodule

// ===== rtl/fbpa_divider.sv =====
`timescale 1ns / 1ps

module fbpa_divider #(
  parameter int AW = 48,
  parameter int DW = 17,
  parameter int QW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient,
  output logic          rem_zero
);

  localparam int WW  = AW + QW;
  localparam int CTW = $clog2(QW + 1);

  logic [WW-1:0]  rem_r;
  logic [WW-1:0]  dsh_r;
  logic [QW-1:0]  q_r;
  logic [CTW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;
  logic           take;

  // Restoring division, one quotient bit per cycle. A remainder left
  // nonzero also covers a quotient that does not fit in QW bits.
  assign take = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= WW'(dividend);
      dsh_r <= WW'(divisor) << (QW - 1);
      q_r   <= '0;
    end else if (run_r) begin
      if (take) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= (q_r << 1) | QW'(take);
      dsh_r <= dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CTW'(QW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                  Handshake
// input     start, busy, in_item                   taken when start & !busy
// result    out_valid, out_result                  one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index/data   taken when valid & ready
//
// A get runs as a free queue read, then slot times stride, then a base add.
// An empty get answers in the cycle after it is taken.
// A put waits on the bit-serial divider, then checks and frees the slot.
// Reset and each configuration beat to index 0, 1 or 2 reinitialize the pool.
// The receiver cannot stall; each item yields exactly one result beat.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fbpa_in_t             in_item,
  output logic                 out_valid,
  output fbpa_out_t            out_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = IW + STRIDE_W;
  localparam logic [STRIDE_W-1:0] STRIDE_RST =
    STRIDE_W'(((BYTES_RST + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES);
  localparam int SLOTS_RST =
    (int'(COUNT_RST) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(COUNT_RST);
  localparam logic [IW-1:0] TAIL_RST =
    (SLOTS_RST >= MAX_ELEMENTS) ? '0 : IW'(SLOTS_RST);

  function automatic logic [CW-1:0] slot_count(input logic [CNT_W-1:0] ec);
    logic [CW+CNT_W-1:0] e;
    e = (CW + CNT_W)'(ec);
    if (e > (CW + CNT_W)'(MAX_ELEMENTS)) begin
      return CW'(MAX_ELEMENTS);
    end
    return e[CW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] free7(input logic [CW-1:0] v);
    logic [CW+CNT_W-1:0] e;
    e = (CW + CNT_W)'(v);
    return e[CNT_W-1:0];
  endfunction

  function automatic logic [IW-1:0] next_index(input logic [IW-1:0] i);
    if (i == IW'(MAX_ELEMENTS - 1)) begin
      return '0;
    end
    return i + IW'(1);
  endfunction

  fbpa_state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]       base_r, base_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [STRIDE_W-1:0]     stride_r, stride_nxt;
  logic [IW-1:0]           head_r, head_nxt;
  logic [IW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           free_r, free_nxt;
  logic [MAX_ELEMENTS-1:0] used_r, used_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  fbpa_out_t               out_r, out_nxt;

  logic [CW-1:0]           slots_c;
  logic [CW-1:0]           slots_new;
  logic [31:0]             bytes_c;
  logic                    init_c;
  logic                    q_rd_en;
  logic [IW-1:0]           q_rd_slot;
  logic                    q_wr_en;
  logic                    div_start;
  logic [ADDR_W-1:0]       div_dividend;
  logic                    div_done;
  logic [IW-1:0]           div_q;
  logic                    div_rem_zero;

  assign slots_c = slot_count(count_r);
  assign bytes_c = (cfg_data[BYTES_W-1:0] == '0) ? 32'd1 : 32'(cfg_data[BYTES_W-1:0]);
  assign div_dividend = in_item.address - base_r;

  fbpa_queue #(
    .DEPTH (MAX_ELEMENTS),
    .IW    (IW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (init_c),
    .rd_en   (q_rd_en),
    .rd_addr (head_r),
    .rd_slot (q_rd_slot),
    .wr_en   (q_wr_en),
    .wr_addr (tail_r),
    .wr_data (div_q)
  );

  fbpa_divider #(
    .AW (ADDR_W),
    .DW (STRIDE_W),
    .QW (IW)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (stride_r),
    .done     (div_done),
    .quotient (div_q),
    .rem_zero (div_rem_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_RST;
      count_r     <= COUNT_RST;
      stride_r    <= STRIDE_RST;
      head_r      <= '0;
      tail_r      <= TAIL_RST;
      free_r      <= CW'(SLOTS_RST);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      stride_r    <= stride_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    count_nxt     = count_r;
    stride_nxt    = stride_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_nxt      = free_r;
    used_nxt      = used_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_rd_en       = 1'b0;
    q_wr_en       = 1'b0;
    div_start     = 1'b0;
    init_c        = 1'b0;
    slots_new     = slots_c;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.kind == KIND_GET) begin
            if (free_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_EMPTY, granted_address: '0,
                                free_slots: free7(free_r)};
            end else begin
              q_rd_en   = 1'b1;
              state_nxt = S_GET_MUL;
            end
          end else begin
            div_start = 1'b1;
            state_nxt = S_PUT_DIV;
          end
        end
      end
      S_GET_MUL: begin
        prod_nxt            = PW'(q_rd_slot) * PW'(stride_r);
        used_nxt[q_rd_slot] = 1'b1;
        head_nxt            = next_index(head_r);
        free_nxt            = free_r - CW'(1);
        state_nxt           = S_GET_SUM;
      end
      S_GET_SUM: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ST_DONE, granted_address: base_r + ADDR_W'(prod_r),
                          free_slots: free7(free_r)};
        state_nxt     = S_IDLE;
      end
      S_PUT_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_BAD_PUT, granted_address: '0,
                            free_slots: free7(free_r)};
          if (div_rem_zero && ((CW + IW)'(div_q) < (CW + IW)'(slots_c))) begin
            if (used_r[div_q]) begin
              q_wr_en         = 1'b1;
              used_nxt[div_q] = 1'b0;
              tail_nxt        = next_index(tail_r);
              free_nxt        = free_r + CW'(1);
              out_nxt         = '{status: ST_DONE, granted_address: '0,
                                  free_slots: free7(free_r + CW'(1))};
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POOL_BASE: begin
          base_nxt = cfg_data;
          init_c   = 1'b1;
        end
        CFG_ELEMENT_COUNT: begin
          count_nxt = cfg_data[CNT_W-1:0];
          init_c    = 1'b1;
        end
        CFG_ELEMENT_BYTES: begin
          stride_nxt = STRIDE_W'(((bytes_c + 32'(LINE_BYTES - 1)) / LINE_BYTES) * LINE_BYTES);
          init_c     = 1'b1;
        end
        default: begin
          init_c = 1'b0;
        end
      endcase
    end

    if (init_c) begin
      slots_new = slot_count(count_nxt);
      head_nxt  = '0;
      tail_nxt  = (slots_new >= CW'(MAX_ELEMENTS)) ? '0 : slots_new[IW-1:0];
      free_nxt  = slots_new;
      used_nxt  = '0;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while an item is still in progress");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + IW)'(free_r) <= (CW + IW)'(slots_c))
    else $error("free count exceeds the slot count");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status != ST_DONE) |-> (out_result.granted_address == '0))
    else $error("failed item reports a nonzero address");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fbpa_pkg::*;

  localparam int SLOTS_MAX = 64;
  localparam int LINE = 64;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  fbpa_in_t in_item = '0;
  logic out_valid;
  fbpa_out_t out_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_BASE;
  logic [ADDR_W-1:0] cfg_data = '0;

  logic [ADDR_W-1:0] cur_base;
  logic [CNT_W-1:0] cur_count;
  logic [BYTES_W-1:0] cur_bytes;
  logic [5:0] free_ring [SLOTS_MAX];
  logic [5:0] ring_rd;
  logic [5:0] ring_wr;
  logic [CNT_W-1:0] n_free;
  logic [SLOTS_MAX-1:0] taken;

  fbpa_out_t replies_due[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  fixed_block_pool_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  function automatic int live_slots();
    return (cur_count > SLOTS_MAX) ? SLOTS_MAX : int'(cur_count);
  endfunction

  function automatic longint unsigned stride_bytes();
    longint unsigned b;
    b = (cur_bytes == 0) ? 1 : longint'(cur_bytes);
    return ((b + LINE - 1) / LINE) * LINE;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(int unsigned slot);
    logic [63:0] sum;
    sum = 64'(cur_base) + 64'(slot) * stride_bytes();
    return sum[ADDR_W-1:0];
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i < SLOTS_MAX; i++) free_ring[i] = 6'(i);
    taken = '0;
    ring_rd = '0;
    ring_wr = 6'(live_slots() % SLOTS_MAX);
    n_free = CNT_W'(live_slots());
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    case (idx)
      CFG_POOL_BASE: cur_base = data;
      CFG_ELEMENT_COUNT: cur_count = data[CNT_W-1:0];
      CFG_ELEMENT_BYTES: cur_bytes = data[BYTES_W-1:0];
      default: return;
    endcase
    reset_pool();
  endfunction

  function automatic fbpa_out_t alloc_reply(fbpa_in_t it);
    fbpa_out_t r;
    logic [ADDR_W-1:0] offset;
    longint unsigned q;
    logic [5:0] slot;
    r = '0;
    r.status = ST_DONE;
    if (it.kind == KIND_GET) begin
      if (n_free == 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot = free_ring[ring_rd];
        ring_rd++;
        n_free--;
        taken[slot] = 1'b1;
        r.granted_address = slot_addr(slot);
      end
    end else begin
      offset = it.address - cur_base;
      q = longint'(offset) / stride_bytes();
      if (longint'(offset) % stride_bytes() != 0 || q >= live_slots() || !taken[q]) begin
        r.status = ST_BAD_PUT;
      end else begin
        taken[q] = 1'b0;
        free_ring[ring_wr] = 6'(q);
        ring_wr++;
        n_free++;
      end
    end
    r.free_slots = n_free;
    return r;
  endfunction

  function automatic fbpa_in_t mk_item(logic kind, logic [ADDR_W-1:0] addr);
    fbpa_in_t it;
    it.kind = kind;
    it.address = addr;
    return it;
  endfunction

  function automatic fbpa_in_t random_item();
    fbpa_in_t it;
    int unsigned pick;
    int used_list[$];
    int free_list[$];
    it = mk_item(KIND_GET, rand48());
    for (int s = 0; s < live_slots(); s++) begin
      if (taken[s]) used_list.push_back(s);
      else free_list.push_back(s);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 90 && used_list.size() == 0)) return it;
    it.kind = KIND_PUT;
    if (pick < 85) begin
      it.address = slot_addr(used_list[$urandom_range(0, used_list.size() - 1)]);
    end else if (pick < 90) begin
      it.address = slot_addr(used_list[$urandom_range(0, used_list.size() - 1)])
                   + ADDR_W'($urandom_range(1, LINE - 1));
    end else if (pick < 94 && free_list.size() != 0) begin
      it.address = slot_addr(free_list[$urandom_range(0, free_list.size() - 1)]);
    end else if (pick < 97) begin
      it.address = slot_addr(live_slots() + $urandom_range(0, 3));
    end
    return it;
  endfunction

  task automatic send_item(fbpa_in_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    replies_due.push_back(alloc_reply(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 60);
      else burst_left = $urandom_range(0, 4);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_pool(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] count,
                          logic [BYTES_W-1:0] bytes);
    cfg_write(CFG_POOL_BASE, base, 1'b0);
    cfg_write(CFG_ELEMENT_COUNT, ADDR_W'(count), 1'b0);
    cfg_write(CFG_ELEMENT_BYTES, ADDR_W'(bytes), 1'b1);
  endtask

  task automatic test_reset_defaults();
    send_item(mk_item(KIND_GET, ADDR_ONES));
    send_item(mk_item(KIND_GET, '0));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_PUT, ADDR_W'(64)));
    send_item(mk_item(KIND_PUT, ADDR_W'(64)));
    send_item(mk_item(KIND_PUT, ADDR_W'(1)));
    send_item(mk_item(KIND_PUT, ADDR_ONES));
    send_item(mk_item(KIND_PUT, ADDR_W'(SLOTS_MAX * LINE)));
    send_item(mk_item(KIND_GET, rand48()));
  endtask

  task automatic test_spare_index();
    settle();
    cfg_write(CFG_SPARE, ADDR_ONES, 1'b1);
    send_item(mk_item(KIND_GET, rand48()));
  endtask

  task automatic test_single_slot();
    logic [ADDR_W-1:0] base;
    settle();
    base = rand48();
    set_pool(base, CNT_W'(1), BYTES_W'(1));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_PUT, base));
    send_item(mk_item(KIND_GET, rand48()));
  endtask

  task automatic test_count_zero();
    settle();
    set_pool(ADDR_ONES, CNT_W'(0), BYTES_W'(65536));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_PUT, ADDR_ONES));
  endtask

  task automatic test_count_above_max();
    settle();
    set_pool(48'hFFFF_FFFF_FFC0, CNT_W'(127), BYTES_W'(0));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_PUT, '0));
    send_item(mk_item(KIND_PUT, slot_addr(SLOTS_MAX)));
  endtask

  task automatic test_widest_stride();
    settle();
    set_pool(rand48(), CNT_W'(2), BYTES_W'(17'h1FFFF));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_GET, rand48()));
    send_item(mk_item(KIND_PUT, slot_addr(1)));
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0] count;
    logic [BYTES_W-1:0] bytes;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = ADDR_ONES - ADDR_W'($urandom_range(0, 4095));
        default: base = rand48();
      endcase
      case ($urandom_range(0, 5))
        0: count = CNT_W'(SLOTS_MAX);
        1: count = CNT_W'($urandom_range(0, 127));
        default: count = CNT_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 4))
        0: bytes = BYTES_W'($urandom_range(0, 1));
        1: bytes = BYTES_W'($urandom_range(65536, 131071));
        default: bytes = BYTES_W'($urandom_range(1, 300));
      endcase
      settle();
      set_pool(base, count, bytes);
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end
  endtask

  always @(posedge clk) begin : check_replies
    fbpa_out_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $error("result beat with none outstanding: %p", out_result);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (out_result.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_result.status);
          errors++;
        end
        if (out_result.granted_address !== want.granted_address) begin
          $error("granted_address mismatch: expected %h, actual %h",
                 want.granted_address, out_result.granted_address);
          errors++;
        end
        if (out_result.free_slots !== want.free_slots) begin
          $error("free_slots mismatch: expected %0d, actual %0d",
                 want.free_slots, out_result.free_slots);
          errors++;
        end
      end
    end
  end

  initial begin
    cur_base = BASE_RST;
    cur_count = COUNT_RST;
    cur_bytes = BYTES_W'(BYTES_RST);
    reset_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_spare_index();
    test_single_slot();
    test_count_zero();
    test_count_above_max();
    test_widest_stride();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fbpa_pkg.sv
rtl/fbpa_queue.sv
rtl/fbpa_divider.sv
rtl/fixed_block_pool_allocator.sv
sim/tb.sv
